// ===== hw/rtl/ddw_pkg.sv =====
// ----------------------------------------------------------------------------
// ddw_pkg
// shared types and constants for the differential drive wheel rpm block
// ----------------------------------------------------------------------------
package ddw_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_HALF_TRACK    = 3'd0;
    localparam logic [2:0] REG_RPM_PER_MPS   = 3'd1;
    localparam logic [2:0] REG_MAX_RPM       = 3'd2;
    localparam logic [2:0] REG_FLIP_LEFT     = 3'd3;
    localparam logic [2:0] REG_FLIP_RIGHT    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd5;

    // register reset values
    localparam logic [15:0] HALF_TRACK_RST    = 16'd14746;
    localparam logic [15:0] RPM_PER_MPS_RST   = 16'd24446;
    localparam logic [18:0] MAX_RPM_RST       = 19'd0;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10;

    // input kind codes
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // configuration register contents
    typedef struct packed {
        logic [15:0] half_track;
        logic [15:0] rpm_per_mps;
        logic [18:0] max_rpm;
        logic        flip_left;
        logic        flip_right;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TURN,
        S_LEFT,
        S_RIGHT,
        S_TICK,
        S_OUT_CMD,
        S_OUT_TICK
    } t_state;

    // shared multiplier operand select
    typedef enum logic [1:0] {
        MS_NONE,
        MS_TURN,
        MS_LEFT,
        MS_RIGHT
    } t_mul_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     capture;
        logic     clr_cnt;
        logic     inc_cnt;
        t_mul_sel mul_sel;
        logic     load_out;
        logic     out_zero;
    } t_ctrl;

    // datapath to controller status
    typedef struct packed {
        logic cnt_expired;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/ddw_regs.sv =====
// ----------------------------------------------------------------------------
// ddw_regs
// apb-style configuration registers, writes and reads
// ----------------------------------------------------------------------------
module ddw_regs
    import ddw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_track    <= HALF_TRACK_RST;
            r_cfg.rpm_per_mps   <= RPM_PER_MPS_RST;
            r_cfg.max_rpm       <= MAX_RPM_RST;
            r_cfg.flip_left     <= 1'b0;
            r_cfg.flip_right    <= 1'b0;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HALF_TRACK:    r_cfg.half_track    <= pwdata[15:0];
                REG_RPM_PER_MPS:   r_cfg.rpm_per_mps   <= pwdata[15:0];
                REG_MAX_RPM:       r_cfg.max_rpm       <= pwdata[18:0];
                REG_FLIP_LEFT:     r_cfg.flip_left     <= pwdata[0];
                REG_FLIP_RIGHT:    r_cfg.flip_right    <= pwdata[0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_HALF_TRACK:    prdata = {16'd0, r_cfg.half_track};
            REG_RPM_PER_MPS:   prdata = {16'd0, r_cfg.rpm_per_mps};
            REG_MAX_RPM:       prdata = {13'd0, r_cfg.max_rpm};
            REG_FLIP_LEFT:     prdata = {31'd0, r_cfg.flip_left};
            REG_FLIP_RIGHT:    prdata = {31'd0, r_cfg.flip_right};
            REG_TIMEOUT_TICKS: prdata = {16'd0, r_cfg.timeout_ticks};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/ddw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddw_ctrl
// sequencer for command and tick words, drives the datapath
// ----------------------------------------------------------------------------
module ddw_ctrl
    import ddw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_kind,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_in_stall     = 1'b1;
        o_ctrl.capture  = 1'b0;
        o_ctrl.clr_cnt  = 1'b0;
        o_ctrl.inc_cnt  = 1'b0;
        o_ctrl.mul_sel  = MS_NONE;
        o_ctrl.load_out = 1'b0;
        o_ctrl.out_zero = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_kind == KIND_CMD) begin
                        o_ctrl.capture = 1'b1;
                        o_ctrl.clr_cnt = 1'b1;
                        n_state        = S_TURN;
                    end else begin
                        o_ctrl.inc_cnt = 1'b1;
                        n_state        = S_TICK;
                    end
                end
            end
            S_TURN: begin
                o_ctrl.mul_sel = MS_TURN;
                n_state        = S_LEFT;
            end
            S_LEFT: begin
                o_ctrl.mul_sel = MS_LEFT;
                n_state        = S_RIGHT;
            end
            S_RIGHT: begin
                o_ctrl.mul_sel = MS_RIGHT;
                n_state        = S_OUT_CMD;
            end
            S_TICK: begin
                n_state = i_stat.cnt_expired ? S_OUT_TICK : S_IDLE;
            end
            S_OUT_CMD: begin
                if (i_stat.out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_OUT_TICK: begin
                if (i_stat.out_free) begin
                    o_ctrl.load_out = 1'b1;
                    o_ctrl.out_zero = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/ddw_datapath.sv =====
// ----------------------------------------------------------------------------
// ddw_datapath
// shared multiplier, wheel rpm shaping, tick counter and output register
// ----------------------------------------------------------------------------
module ddw_datapath
    import ddw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_ctrl              i_ctrl,
    input  logic signed [15:0] i_linear_velocity,
    input  logic signed [15:0] i_angular_velocity,
    input  logic               i_out_stall,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic signed [19:0] o_left_speed,
    output logic signed [19:0] o_right_speed,
    output logic               o_timed_out
);

    logic signed [15:0] r_v;
    logic signed [15:0] r_w;
    logic signed [16:0] r_turn;
    logic signed [19:0] r_left;
    logic signed [19:0] r_right;
    logic        [15:0] r_cnt;
    logic               r_out_valid;

    logic signed [17:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [34:0] prod;
    logic signed [17:0] speed;
    logic               inv;
    logic signed [18:0] rpm_raw;
    logic signed [19:0] rpm_sgn;
    logic signed [19:0] lim;
    logic signed [19:0] rpm_out;

    // left speed is v minus turn, right speed is v plus turn
    always_comb begin
        if (i_ctrl.mul_sel == MS_LEFT) begin
            speed = 18'(r_v) - 18'(r_turn);
        end else begin
            speed = 18'(r_v) + 18'(r_turn);
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (i_ctrl.mul_sel)
            MS_TURN: begin
                mul_a = 18'(r_w);
                mul_b = signed'({1'b0, i_cfg.half_track});
            end
            MS_LEFT, MS_RIGHT: begin
                mul_a = speed;
                mul_b = signed'({1'b0, i_cfg.rpm_per_mps});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 35'(mul_a) * 35'(mul_b);

    // floor shift to q.4, optional negate, symmetric clamp when max_rpm is nonzero
    // the clamped value already lies inside the 20-bit output range
    assign rpm_raw = prod[34:16];
    assign inv     = (i_ctrl.mul_sel == MS_LEFT) ? i_cfg.flip_left : i_cfg.flip_right;
    assign rpm_sgn = inv ? -20'(rpm_raw) : 20'(rpm_raw);
    assign lim     = signed'({1'b0, i_cfg.max_rpm});

    always_comb begin
        rpm_out = rpm_sgn;
        if (i_cfg.max_rpm != '0) begin
            if (rpm_sgn > lim) begin
                rpm_out = lim;
            end else if (rpm_sgn < -lim) begin
                rpm_out = -lim;
            end
        end
    end

    // operand capture and intermediate results
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_v <= i_linear_velocity;
            r_w <= i_angular_velocity;
        end
        unique case (i_ctrl.mul_sel)
            MS_TURN:  r_turn  <= prod[32:16];
            MS_LEFT:  r_left  <= rpm_out;
            MS_RIGHT: r_right <= rpm_out;
            default: ;
        endcase
    end

    // ticks since the last command, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_ctrl.inc_cnt && (r_cnt != '1)) begin
            r_cnt <= r_cnt + 16'd1;
        end
    end

    assign o_stat.cnt_expired = (r_cnt > i_cfg.timeout_ticks);
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            o_left_speed  <= i_ctrl.out_zero ? '0 : r_left;
            o_right_speed <= i_ctrl.out_zero ? '0 : r_right;
            o_timed_out   <= i_ctrl.out_zero;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/diff_drive_wheel_rpm_with_watchdog.sv =====
// ----------------------------------------------------------------------------
// diff_drive_wheel_rpm_with_watchdog
// differential drive wheel rpm converter with a command watchdog
// ----------------------------------------------------------------------------
// A command word (kind 0) goes from acceptance to a loaded output word
// through an accept step and three passes through the single shared
// 18x17 multiplier (turn term, left wheel, right wheel), then the output load.
// A tick word (kind 1) is counted and produces nothing, unless the
// watchdog has expired, in which case a zero pair marked timed_out is sent.
// One word is worked on at a time; the output register lets a finished word
// wait for the sink while the next word is accepted and processed, and the
// sequencer only holds at its final load step if the previous word is still
// waiting.
module diff_drive_wheel_rpm_with_watchdog
    import ddw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic signed [15:0] i_linear_velocity,
    input  logic signed [15:0] i_angular_velocity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [19:0] o_left_speed,
    output logic signed [19:0] o_right_speed,
    output logic               o_timed_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg  cfg;
    t_ctrl ctrl;
    t_stat stat;

    // configuration registers
    ddw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    ddw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_ctrl     (ctrl)
    );

    // arithmetic and output register
    ddw_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_ctrl             (ctrl),
        .i_linear_velocity  (i_linear_velocity),
        .i_angular_velocity (i_angular_velocity),
        .i_out_stall        (i_out_stall),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .o_left_speed       (o_left_speed),
        .o_right_speed      (o_right_speed),
        .o_timed_out        (o_timed_out)
    );

endmodule
